// ===== design/gpt_pkg.sv =====
// Package with shared constants and state types of the grid percolation tracker.
package gpt_pkg;

  localparam int DEF_MAX_GRID = 32;
  localparam int CFG_W        = 6;
  localparam int COORD_W      = 5;
  localparam int COUNT_W      = 11;
  localparam logic [CFG_W-1:0] GRID_RESET = 6'd32;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SITE,
    ST_NB,
    ST_NBCHK,
    ST_FSTART,
    ST_FIND,
    ST_JW1,
    ST_JW2,
    ST_MARK,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_TOP,
    PH_BOT
  } phase_t;

endpackage

// ===== design/gpt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module gpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/grid_percolation_tracker_top.sv =====
// Top level of the grid percolation tracker: weighted union-find over a site grid in RAM.
//
// Each transaction addresses one site and yields one result. Requests are handled one at a
// time, and the input stalls until the result of the current request has been loaded into
// the output register; that load waits while an earlier result is still held there by a
// stall. An out of range request goes straight to the output. A query, or an open of an
// already open site, first reads the site's open bit. Opening a closed site also involves:
//   - a read of the open bit of each of the up to four grid neighbors,
//   - a union tried with each open neighbor, or with the top or bottom node on an edge row,
//   - a parent-chain walk for each root search, and a weighted merge when the roots differ.
// The last two root searches find the roots of the top and bottom nodes. Weighted unions
// keep every chain short. After reset and after every write of the grid size register, a
// clearing pass restores the RAMs. No request is accepted during it.
module grid_percolation_tracker_top #(
  parameter int MAX_GRID = gpt_pkg::DEF_MAX_GRID
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gpt_pkg::CFG_W-1:0]   cfg_grid_size,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [gpt_pkg::COORD_W-1:0] in_row,
  input  logic [gpt_pkg::COORD_W-1:0] in_col,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_was_open,
  output logic                        out_system_percolates,
  output logic [gpt_pkg::COUNT_W-1:0] out_open_count,
  output logic                        out_out_of_range
);

  import gpt_pkg::*;

  localparam int SITES = MAX_GRID * MAX_GRID;
  localparam int NODES = SITES + 2;
  localparam int SW    = $clog2(SITES);
  localparam int NW    = $clog2(NODES);
  localparam int WW    = $clog2(NODES + 1);
  localparam int PW    = NW + WW;
  localparam logic [NW-1:0] TOP_NODE = NW'(SITES);
  localparam logic [NW-1:0] BOT_NODE = NW'(SITES + 1);
  localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);
  localparam logic [NW-1:0] STRIDE = NW'(MAX_GRID);
  localparam logic [6:0] MAXG7 = 7'(MAX_GRID);

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [CFG_W-1:0]   grid_r, grid_nxt;
  logic [NW-1:0]      clr_r, clr_nxt;
  logic               action_r, action_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic               was_r, was_nxt;
  logic               bad_r, bad_nxt;
  logic               perc_r, perc_nxt;
  logic [COUNT_W-1:0] tally_r, tally_nxt;
  logic [1:0]         k_r, k_nxt;
  logic [NW-1:0]      cur_r, cur_nxt;
  logic [NW-1:0]      tgt_r, tgt_nxt;
  logic [NW-1:0]      ra_r, ra_nxt;
  logic [NW-1:0]      rb_r, rb_nxt;
  logic [WW-1:0]      wa_r, wa_nxt;
  logic [WW-1:0]      wb_r, wb_nxt;

  logic               ov_r, ov_nxt;
  logic               o_was_r, o_was_nxt;
  logic               o_perc_r, o_perc_nxt;
  logic [COUNT_W-1:0] o_cnt_r, o_cnt_nxt;
  logic               o_bad_r, o_bad_nxt;

  logic          om_we, om_wdata, om_rdata;
  logic [SW-1:0] om_waddr, om_raddr;
  logic          pm_we;
  logic [NW-1:0] pm_waddr, pm_raddr;
  logic [PW-1:0] pm_wdata, pm_rdata;

  logic [6:0]    n_c, in_row7, in_col7, row7, col7;
  logic          in_bad_c, top_row_c, last_row_c, last_col_c;
  logic [NW-1:0] in_site_c, site_c, rd_par_c;
  logic [WW-1:0] rd_wt_c;
  logic          accept_c, emit_free_c;

  gpt_ram #(.WIDTH(1), .DEPTH(SITES)) u_open_ram (
    .clk   (clk),
    .we    (om_we),
    .waddr (om_waddr),
    .wdata (om_wdata),
    .raddr (om_raddr),
    .rdata (om_rdata)
  );

  gpt_ram #(.WIDTH(PW), .DEPTH(NODES)) u_link_ram (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .raddr (pm_raddr),
    .rdata (pm_rdata)
  );

  assign n_c        = ({1'b0, grid_r} > MAXG7) ? MAXG7 : {1'b0, grid_r};
  assign in_row7    = {2'b00, in_row};
  assign in_col7    = {2'b00, in_col};
  assign row7       = {2'b00, row_r};
  assign col7       = {2'b00, col_r};
  assign in_bad_c   = (in_row7 >= n_c) || (in_col7 >= n_c);
  assign in_site_c  = NW'(32'(in_row) * MAX_GRID + 32'(in_col));
  assign site_c     = NW'(32'(row_r) * MAX_GRID + 32'(col_r));
  assign top_row_c  = (row_r == '0);
  assign last_row_c = (row7 == n_c - 7'd1);
  assign last_col_c = (col7 == n_c - 7'd1);
  assign rd_par_c   = pm_rdata[PW-1:WW];
  assign rd_wt_c    = pm_rdata[WW-1:0];

  assign in_stall    = (state_r != ST_IDLE);
  assign accept_c    = in_valid && !in_stall;
  assign cfg_ready   = 1'b1;
  assign emit_free_c = !ov_r || !out_stall;

  assign out_valid             = ov_r;
  assign out_was_open          = o_was_r;
  assign out_system_percolates = o_perc_r;
  assign out_open_count        = o_cnt_r;
  assign out_out_of_range      = o_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      grid_r  <= GRID_RESET;
      clr_r   <= '0;
      perc_r  <= 1'b0;
      tally_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      grid_r  <= grid_nxt;
      clr_r   <= clr_nxt;
      perc_r  <= perc_nxt;
      tally_r <= tally_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r  <= phase_nxt;
    action_r <= action_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    was_r    <= was_nxt;
    bad_r    <= bad_nxt;
    k_r      <= k_nxt;
    cur_r    <= cur_nxt;
    tgt_r    <= tgt_nxt;
    ra_r     <= ra_nxt;
    rb_r     <= rb_nxt;
    wa_r     <= wa_nxt;
    wb_r     <= wb_nxt;
    o_was_r  <= o_was_nxt;
    o_perc_r <= o_perc_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_bad_r  <= o_bad_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    grid_nxt   = grid_r;
    clr_nxt    = clr_r;
    action_nxt = action_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    was_nxt    = was_r;
    bad_nxt    = bad_r;
    perc_nxt   = perc_r;
    tally_nxt  = tally_r;
    k_nxt      = k_r;
    cur_nxt    = cur_r;
    tgt_nxt    = tgt_r;
    ra_nxt     = ra_r;
    rb_nxt     = rb_r;
    wa_nxt     = wa_r;
    wb_nxt     = wb_r;
    ov_nxt     = ov_r && out_stall;
    o_was_nxt  = o_was_r;
    o_perc_nxt = o_perc_r;
    o_cnt_nxt  = o_cnt_r;
    o_bad_nxt  = o_bad_r;
    om_we      = 1'b0;
    om_waddr   = site_c[SW-1:0];
    om_wdata   = 1'b1;
    om_raddr   = tgt_r[SW-1:0];
    pm_we      = 1'b0;
    pm_waddr   = ra_r;
    pm_wdata   = '0;
    pm_raddr   = cur_r;

    unique case (state_r)
      ST_CLEAR: begin
        pm_we    = 1'b1;
        pm_waddr = clr_r;
        pm_wdata = {clr_r, WW'(1)};
        om_we    = (32'(clr_r) < SITES);
        om_waddr = clr_r[SW-1:0];
        om_wdata = 1'b0;
        tally_nxt = '0;
        perc_nxt  = 1'b0;
        if (clr_r == LAST_NODE) begin
          clr_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + NW'(1);
        end
      end
      ST_IDLE: begin
        om_raddr = in_site_c[SW-1:0];
        if (accept_c) begin
          action_nxt = in_action;
          row_nxt    = in_row;
          col_nxt    = in_col;
          bad_nxt    = in_bad_c;
          was_nxt    = 1'b0;
          state_nxt  = in_bad_c ? ST_EMIT : ST_SITE;
        end
      end
      ST_SITE: begin
        was_nxt = om_rdata;
        k_nxt   = 2'd0;
        if (action_r || om_rdata) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_NB;
        end
      end
      ST_NB: begin
        cur_nxt   = site_c;
        phase_nxt = PH_A;
        unique case (k_r)
          2'd0: begin
            if (top_row_c) begin
              tgt_nxt   = TOP_NODE;
              state_nxt = ST_FSTART;
            end else begin
              tgt_nxt   = site_c - STRIDE;
              state_nxt = ST_NBCHK;
            end
          end
          2'd1: begin
            if (last_row_c) begin
              tgt_nxt   = BOT_NODE;
              state_nxt = ST_FSTART;
            end else begin
              tgt_nxt   = site_c + STRIDE;
              state_nxt = ST_NBCHK;
            end
          end
          2'd2: begin
            tgt_nxt = site_c - NW'(1);
            if (col_r != '0) begin
              state_nxt = ST_NBCHK;
            end else begin
              k_nxt = 2'd3;
            end
          end
          default: begin
            tgt_nxt = site_c + NW'(1);
            if (!last_col_c) begin
              state_nxt = ST_NBCHK;
            end else begin
              state_nxt = ST_MARK;
            end
          end
        endcase
        om_raddr = tgt_nxt[SW-1:0];
      end
      ST_NBCHK: begin
        if (om_rdata) begin
          state_nxt = ST_FSTART;
        end else if (k_r == 2'd3) begin
          state_nxt = ST_MARK;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_NB;
        end
      end
      ST_FSTART: begin
        pm_raddr  = cur_r;
        state_nxt = ST_FIND;
      end
      ST_FIND: begin
        if (rd_par_c != cur_r) begin
          cur_nxt  = rd_par_c;
          pm_raddr = rd_par_c;
        end else begin
          unique case (phase_r)
            PH_A: begin
              ra_nxt    = cur_r;
              wa_nxt    = rd_wt_c;
              cur_nxt   = tgt_r;
              pm_raddr  = tgt_r;
              phase_nxt = PH_B;
            end
            PH_B: begin
              rb_nxt = cur_r;
              wb_nxt = rd_wt_c;
              if (ra_r != cur_r) begin
                state_nxt = ST_JW1;
              end else if (k_r == 2'd3) begin
                state_nxt = ST_MARK;
              end else begin
                k_nxt     = k_r + 2'd1;
                state_nxt = ST_NB;
              end
            end
            PH_TOP: begin
              ra_nxt    = cur_r;
              cur_nxt   = BOT_NODE;
              pm_raddr  = BOT_NODE;
              phase_nxt = PH_BOT;
            end
            default: begin
              perc_nxt  = (ra_r == cur_r);
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end
      ST_JW1: begin
        pm_we = 1'b1;
        if (wa_r < wb_r) begin
          pm_waddr = ra_r;
          pm_wdata = {rb_r, wa_r};
        end else begin
          pm_waddr = rb_r;
          pm_wdata = {ra_r, wb_r};
        end
        state_nxt = ST_JW2;
      end
      ST_JW2: begin
        pm_we = 1'b1;
        if (wa_r < wb_r) begin
          pm_waddr = rb_r;
          pm_wdata = {rb_r, wa_r + wb_r};
        end else begin
          pm_waddr = ra_r;
          pm_wdata = {ra_r, wa_r + wb_r};
        end
        if (k_r == 2'd3) begin
          state_nxt = ST_MARK;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_NB;
        end
      end
      ST_MARK: begin
        om_we     = 1'b1;
        om_waddr  = site_c[SW-1:0];
        om_wdata  = 1'b1;
        tally_nxt = tally_r + COUNT_W'(1);
        cur_nxt   = TOP_NODE;
        phase_nxt = PH_TOP;
        state_nxt = ST_FSTART;
      end
      ST_EMIT: begin
        if (emit_free_c) begin
          ov_nxt     = 1'b1;
          o_was_nxt  = was_r;
          o_perc_nxt = perc_r;
          o_cnt_nxt  = tally_r;
          o_bad_nxt  = bad_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    if (cfg_valid && cfg_ready) begin
      grid_nxt  = cfg_grid_size;
      clr_nxt   = '0;
      state_nxt = ST_CLEAR;
    end
  end

endmodule

// ===== design/gpt_checker.sv =====
// Port-level checker for the grid percolation tracker and its bind statement.
module gpt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_was_open,
  input logic        out_system_percolates,
  input logic [10:0] out_open_count,
  input logic        out_out_of_range
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_open_count))
    else $error("Stalled result transaction changed or vanished.");

  a_bad_not_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_out_of_range && out_was_open))
    else $error("Out of range result reports an open site.");

  a_empty_no_perc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_open_count == 11'd0) |-> !out_system_percolates)
    else $error("Percolation reported with no open sites.");

endmodule

bind grid_percolation_tracker_top gpt_checker u_gpt_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_was_open          (out_was_open),
  .out_system_percolates (out_system_percolates),
  .out_open_count        (out_open_count),
  .out_out_of_range      (out_out_of_range)
);
